>>> rtl/sts_pkg.sv
// shared types and codes of the sorted table search and insert block
`default_nettype none
package sts_pkg;

    typedef logic [1:0] status_t;

    localparam status_t STATUS_OK   = 2'd0;
    localparam status_t STATUS_DUP  = 2'd1;
    localparam status_t STATUS_FULL = 2'd2;

    localparam logic CMD_FIND   = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

endpackage
`default_nettype wire

>>> rtl/sts_ram.sv
// generic single write port ram with one registered read port
`default_nettype none
module sts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

>>> rtl/sorted_table_search_insert.sv
// top level: sorted key/value table with binary search and ordered insert
`default_nettype none
// channel   dir   tdata fields (low bit up)                         tuser
// s_        in    key, value                                         cmd
// m_        out   found, position, status, found_value, entry_count  -
//
// find: a binary search over the held entries, paced by the single registered read
//   port of the key ram (one probe costs a read in PROBE and a compare in CMP)
// an insert of an absent key moves entries position..count-1 up one place,
//   one entry per cycle through the same read port, then writes the new record
// reset: only control and the record count are cleared; the rams need no pass
// stalls: s_tready is high only between items; a result waits in the output
//   register and the next item is taken meanwhile, it finishes once m_ is free
module sorted_table_search_insert
    import sts_pkg::*;
#(
    parameter int DEPTH      = 256,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32,
    localparam int IDX_W     = $clog2(DEPTH),
    localparam int CNT_W     = $clog2(DEPTH + 1),
    localparam int IN_TW     = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8,
    localparam int OUT_BITS  = 1 + CNT_W + 2 + VALUE_BITS + CNT_W,
    localparam int OUT_TW    = ((OUT_BITS + 7) / 8) * 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [IN_TW-1:0]  s_tdata,   // key, value
    input  wire logic [0:0]        s_tuser,   // cmd
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [OUT_TW-1:0] m_tdata    // found, position, status, found_value,
                                              // entry_count
);

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PROBE = 3'd1;  // pick mid and read it, or read final slot
    localparam logic [2:0] ST_CMP   = 3'd2;  // narrow the range with the read key
    localparam logic [2:0] ST_HIT   = 3'd3;  // check for a match and decide
    localparam logic [2:0] ST_SHIFT = 3'd4;  // move one entry up per cycle
    localparam logic [2:0] ST_WRITE = 3'd5;  // write new record at insertion point
    localparam logic [2:0] ST_OUT   = 3'd6;  // hand result to output register

    logic [2:0]            state_reg, state_next;
    logic                  cmd_reg, cmd_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic [CNT_W-1:0]      lo_reg, lo_next;
    logic [CNT_W-1:0]      hi_reg, hi_next;
    logic [CNT_W-1:0]      mid_reg, mid_next;
    logic [IDX_W-1:0]      ptr_reg, ptr_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  hit_reg, hit_next;
    logic [VALUE_BITS-1:0] fval_reg, fval_next;
    status_t               status_reg, status_next;

    // output register
    logic                  m_valid_reg, m_valid_next;
    logic                  o_found_reg, o_found_next;
    logic [CNT_W-1:0]      o_pos_reg, o_pos_next;
    status_t               o_status_reg, o_status_next;
    logic [VALUE_BITS-1:0] o_fval_reg, o_fval_next;
    logic [CNT_W-1:0]      o_count_reg, o_count_next;

    // ram ports, shared address for key and value stores
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [KEY_BITS-1:0]   wr_key;
    logic [VALUE_BITS-1:0] wr_value;
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_value;

    // shared compare unit
    logic                  key_less;
    logic                  key_equal;
    logic [CNT_W-1:0]      mid_calc;
    logic [CNT_W-1:0]      ptr_dec;
    logic                  s_xfer;

    assign key_less  = rd_key < key_reg;
    assign key_equal = rd_key == key_reg;
    assign mid_calc  = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign ptr_dec   = CNT_W'(ptr_reg) - CNT_W'(1);

    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_TW'({o_count_reg, o_fval_reg, o_status_reg, o_pos_reg,
                               o_found_reg});

    sts_ram #(.WIDTH(KEY_BITS), .DEPTH(DEPTH)) u_key_ram (
        .clk   (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_key),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_key)
    );

    sts_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_value_ram (
        .clk   (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_value),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_value)
    );

    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        key_next      = key_reg;
        value_next    = value_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        ptr_next      = ptr_reg;
        count_next    = count_reg;
        hit_next      = hit_reg;
        fval_next     = fval_reg;
        status_next   = status_reg;
        m_valid_next  = m_valid_reg;
        o_found_next  = o_found_reg;
        o_pos_next    = o_pos_reg;
        o_status_next = o_status_reg;
        o_fval_next   = o_fval_reg;
        o_count_next  = o_count_reg;
        rd_en         = 1'b0;
        rd_addr       = '0;
        wr_en         = 1'b0;
        wr_addr       = ptr_reg;
        wr_key        = rd_key;
        wr_value      = rd_value;

        // result taken downstream
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    cmd_next   = s_tuser[0];
                    key_next   = s_tdata[KEY_BITS-1:0];
                    value_next = s_tdata[KEY_BITS +: VALUE_BITS];
                    lo_next    = '0;
                    hi_next    = count_reg;
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (lo_reg < hi_reg) begin
                    mid_next   = mid_calc;
                    rd_en      = 1'b1;
                    rd_addr    = mid_calc[IDX_W-1:0];
                    state_next = ST_CMP;
                end else begin
                    // lower bound settled, fetch it when it is a held entry
                    rd_en      = (lo_reg < count_reg);
                    rd_addr    = lo_reg[IDX_W-1:0];
                    state_next = ST_HIT;
                end
            end
            ST_CMP: begin
                if (key_less) begin
                    lo_next = mid_reg + CNT_W'(1);
                end else begin
                    hi_next = mid_reg;
                end
                state_next = ST_PROBE;
            end
            ST_HIT: begin
                hit_next    = (lo_reg < count_reg) && key_equal;
                fval_next   = '0;
                status_next = STATUS_OK;
                state_next  = ST_OUT;
                if ((lo_reg < count_reg) && key_equal) begin
                    fval_next = rd_value;
                    if (cmd_reg == CMD_INSERT) begin
                        status_next = STATUS_DUP;
                    end
                end else if (cmd_reg == CMD_INSERT) begin
                    if (count_reg == CNT_W'(DEPTH)) begin
                        status_next = STATUS_FULL;
                    end else begin
                        ptr_next = count_reg[IDX_W-1:0];
                        if (count_reg > lo_reg) begin
                            // prime the move-up with the top entry
                            rd_en      = 1'b1;
                            rd_addr    = IDX_W'(count_reg - CNT_W'(1));
                            state_next = ST_SHIFT;
                        end else begin
                            state_next = ST_WRITE;
                        end
                    end
                end
            end
            ST_SHIFT: begin
                // entry read last cycle lands one place up
                wr_en    = 1'b1;
                wr_addr  = ptr_reg;
                ptr_next = ptr_dec[IDX_W-1:0];
                if (ptr_dec > lo_reg) begin
                    rd_en   = 1'b1;
                    rd_addr = IDX_W'(ptr_dec - CNT_W'(1));
                end else begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                wr_en      = 1'b1;
                wr_addr    = lo_reg[IDX_W-1:0];
                wr_key     = key_reg;
                wr_value   = value_reg;
                count_next = count_reg + CNT_W'(1);
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    o_found_next  = hit_reg;
                    o_pos_next    = lo_reg;
                    o_status_next = status_reg;
                    o_fval_next   = fval_reg;
                    o_count_next  = count_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        value_reg    <= value_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        ptr_reg      <= ptr_next;
        hit_reg      <= hit_next;
        fval_reg     <= fval_next;
        status_reg   <= status_next;
        o_found_reg  <= o_found_next;
        o_pos_reg    <= o_pos_next;
        o_status_reg <= o_status_next;
        o_fval_reg   <= o_fval_next;
        o_count_reg  <= o_count_next;
    end

endmodule
`default_nettype wire
